[rtl/core/shp_pkg.sv]
// Types and constants shared by the segment header packer.
`default_nettype none
package shp_pkg;

  typedef enum logic {
    OP_HEADER = 1'b0,
    OP_REFERENCE = 1'b1
  } shp_op_t;

  // Largest referred-to count the header accepts; larger counts are clamped.
  localparam logic [4:0] MAX_REFS = 5'd31;
  // Counts above this use the long count and retention form.
  localparam logic [4:0] SHORT_FORM_MAX = 5'd4;
  // Immediate lossless generic region: data length is sent as all ones.
  localparam logic [5:0] SEG_TYPE_IMM_LOSSLESS = 6'd38;
  // Bytes one item can produce at most.
  localparam int RUN_BYTES = 14;
  localparam int TAIL_BYTES = 8;
  localparam logic [31:0] REF_ONE_BYTE_MAX = 32'd256;
  localparam logic [31:0] REF_TWO_BYTE_MAX = 32'd65536;
  localparam logic [7:0] LONG_FORM_MARK = 8'hE0;

  typedef struct packed {
    shp_op_t operation;
    logic [31:0] seg_number;
    logic [5:0] seg_type;
    logic wide_page_field;
    logic deferred_non_retain;
    logic [4:0] ref_count;
    logic [31:0] retain_bits;
    logic [31:0] page_assoc;
    logic [31:0] data_length;
    logic [31:0] referred_number;
  } shp_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic last_of_run;
    logic header_complete;
  } shp_out_t;

endpackage
`default_nettype wire

[rtl/core/segment_header_packer_unit.sv]
// Segment header packer: turns header and reference items into header bytes.
// An accepted item loads the byte buffer, whose bytes are registered onto the output.
// Throughput: one byte per cycle while out_stall is low. An item producing n bytes
// (up to 14) holds the byte buffer until its last byte leaves, and the next item is
// taken in the cycle its last byte leaves. An item with no bytes loads nothing.
// Reset (rst_n low, synchronous) empties the buffer and output and clears saved state.
`default_nettype none
module segment_header_packer_unit (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_stall,
  input  wire shp_pkg::shp_in_t in_data,
  output logic             out_valid,
  input  wire              out_stall,
  output shp_pkg::shp_out_t out_data
);
  import shp_pkg::*;

  // Saved header state
  logic [4:0]  refs_pending_r;
  logic [31:0] saved_seg_number_r;
  logic        saved_wide_page_r;
  logic [31:0] saved_page_assoc_r;
  logic [31:0] saved_length_r;

  // Byte buffer for the run of the current item
  logic                       run_valid_r;
  logic [3:0]                 run_left_r;
  logic                       run_tail_r;
  logic [RUN_BYTES-1:0][7:0]  run_bytes_r;

  logic     out_valid_r;
  shp_out_t out_data_r;

  logic out_free;
  logic run_move;
  logic run_last_move;
  logic in_accept;
  logic hdr_item;

  logic [4:0]  ref_cnt;
  logic [31:0] retain_m;
  logic [7:0]  flags;
  logic [31:0] len_in;
  logic [5:0]  ret_bytes;

  logic [RUN_BYTES-1:0][7:0]  head;
  logic [3:0]                 head_len;
  logic                       tail_en;
  logic                       tail_wide;
  logic [31:0]                tail_page;
  logic [31:0]                tail_len;
  logic [TAIL_BYTES-1:0][7:0] tail;
  logic [3:0]                 tail_cnt;

  logic [RUN_BYTES-1:0][7:0]  bytes_nxt;
  logic [3:0]                 cnt_nxt;

  assign out_free      = !out_valid_r || !out_stall;
  assign run_move      = run_valid_r && out_free;
  assign run_last_move = run_move && (run_left_r == 4'd1);
  assign in_stall      = run_valid_r && !run_last_move;
  assign in_accept     = in_valid && !in_stall;
  assign hdr_item      = (in_data.operation == OP_HEADER);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Header field preparation
  always_comb begin
    ref_cnt = (in_data.ref_count > MAX_REFS) ? MAX_REFS : in_data.ref_count;
    for (int j = 0; j < 32; j++) begin
      retain_m[j] = in_data.retain_bits[j] && (6'(j) <= {1'b0, ref_cnt});
    end
    flags = {in_data.deferred_non_retain, in_data.wide_page_field, in_data.seg_type};
    len_in = (in_data.seg_type == SEG_TYPE_IMM_LOSSLESS) ? '1 : in_data.data_length;
    ret_bytes = (6'(ref_cnt) + 6'd8) >> 3;
  end

  // Leading bytes of the run and where the tail comes from
  always_comb begin
    head      = '0;
    head_len  = 4'd0;
    tail_en   = 1'b0;
    tail_wide = saved_wide_page_r;
    tail_page = saved_page_assoc_r;
    tail_len  = saved_length_r;
    if (hdr_item) begin
      head[0] = in_data.seg_number[31:24];
      head[1] = in_data.seg_number[23:16];
      head[2] = in_data.seg_number[15:8];
      head[3] = in_data.seg_number[7:0];
      head[4] = flags;
      if (ref_cnt <= SHORT_FORM_MAX) begin
        head[5]  = {ref_cnt[2:0], retain_m[4:0]};
        head_len = 4'd6;
      end else begin
        head[5]  = LONG_FORM_MARK;
        head[6]  = 8'h00;
        head[7]  = 8'h00;
        head[8]  = {3'b000, ref_cnt};
        head[9]  = retain_m[7:0];
        head[10] = retain_m[15:8];
        head[11] = retain_m[23:16];
        head[12] = retain_m[31:24];
        head_len = 4'd9 + ret_bytes[3:0];
      end
      tail_en   = (ref_cnt == 5'd0);
      tail_wide = in_data.wide_page_field;
      tail_page = in_data.page_assoc;
      tail_len  = len_in;
    end else if (refs_pending_r != 5'd0) begin
      tail_en = (refs_pending_r == 5'd1);
      if (saved_seg_number_r <= REF_ONE_BYTE_MAX) begin
        head[0]  = in_data.referred_number[7:0];
        head_len = 4'd1;
      end else if (saved_seg_number_r <= REF_TWO_BYTE_MAX) begin
        head[0]  = in_data.referred_number[15:8];
        head[1]  = in_data.referred_number[7:0];
        head_len = 4'd2;
      end else begin
        head[0]  = in_data.referred_number[31:24];
        head[1]  = in_data.referred_number[23:16];
        head[2]  = in_data.referred_number[15:8];
        head[3]  = in_data.referred_number[7:0];
        head_len = 4'd4;
      end
    end
  end

  // Page association and data length
  always_comb begin
    tail = '0;
    if (tail_wide) begin
      tail[0]  = tail_page[31:24];
      tail[1]  = tail_page[23:16];
      tail[2]  = tail_page[15:8];
      tail[3]  = tail_page[7:0];
      tail[4]  = tail_len[31:24];
      tail[5]  = tail_len[23:16];
      tail[6]  = tail_len[15:8];
      tail[7]  = tail_len[7:0];
      tail_cnt = 4'd8;
    end else begin
      tail[0]  = tail_page[7:0];
      tail[1]  = tail_len[31:24];
      tail[2]  = tail_len[23:16];
      tail[3]  = tail_len[15:8];
      tail[4]  = tail_len[7:0];
      tail_cnt = 4'd5;
    end
  end

  // Place the tail straight after the leading bytes
  always_comb begin
    for (int i = 0; i < RUN_BYTES; i++) begin
      if (4'(i) < head_len) begin
        bytes_nxt[i] = head[i];
      end else if (tail_en && ((4'(i) - head_len) < tail_cnt)) begin
        bytes_nxt[i] = tail[3'(4'(i) - head_len)];
      end else begin
        bytes_nxt[i] = 8'h00;
      end
    end
    cnt_nxt = head_len + (tail_en ? tail_cnt : 4'd0);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_valid_r        <= 1'b0;
      run_left_r         <= 4'd0;
      run_tail_r         <= 1'b0;
      out_valid_r        <= 1'b0;
      refs_pending_r     <= 5'd0;
      saved_seg_number_r <= 32'd0;
      saved_wide_page_r  <= 1'b0;
      saved_page_assoc_r <= 32'd0;
      saved_length_r     <= 32'd0;
    end else begin
      if (out_free) begin
        out_valid_r <= run_valid_r;
      end
      if (in_accept && (cnt_nxt != 4'd0)) begin
        run_valid_r <= 1'b1;
        run_left_r  <= cnt_nxt;
        run_tail_r  <= tail_en;
      end else if (run_move) begin
        run_left_r <= run_left_r - 4'd1;
        if (run_left_r == 4'd1) begin
          run_valid_r <= 1'b0;
        end
      end
      if (in_accept) begin
        if (hdr_item) begin
          refs_pending_r     <= ref_cnt;
          saved_seg_number_r <= in_data.seg_number;
          saved_wide_page_r  <= in_data.wide_page_field;
          saved_page_assoc_r <= in_data.page_assoc;
          saved_length_r     <= len_in;
        end else if (refs_pending_r != 5'd0) begin
          refs_pending_r <= refs_pending_r - 5'd1;
        end
      end
    end
  end

  // Payload: load the run, advance it one byte per move
  always_ff @(posedge clk) begin
    if (in_accept && (cnt_nxt != 4'd0)) begin
      run_bytes_r <= bytes_nxt;
    end else if (run_move) begin
      run_bytes_r <= {8'h00, run_bytes_r[RUN_BYTES-1:1]};
    end
    if (run_move) begin
      out_data_r.out_byte        <= run_bytes_r[0];
      out_data_r.last_of_run     <= (run_left_r == 4'd1);
      out_data_r.header_complete <= (run_left_r == 4'd1) && run_tail_r;
    end
  end

  a_hold_run: assert property (@(posedge clk) disable iff (!rst_n)
    (run_valid_r && (run_left_r > 4'd1)) |-> in_stall)
    else $error("item accepted while the byte run is unfinished");

  a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
    run_valid_r |-> ((run_left_r != 4'd0) && (run_left_r <= 4'(RUN_BYTES))))
    else $error("byte run count out of range");

  a_complete_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.header_complete) |-> out_data_r.last_of_run)
    else $error("header end marked on a byte that does not end its item");

  a_pending_max: assert property (@(posedge clk) disable iff (!rst_n)
    refs_pending_r <= MAX_REFS)
    else $error("pending reference count above limit");

  a_ref_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !hdr_item && (refs_pending_r != 5'd0))
      |=> (refs_pending_r == $past(refs_pending_r) - 5'd1))
    else $error("pending reference count did not advance");

endmodule
`default_nettype wire

[test/shp_byte_checker.sv]
// Checker for the segment header packer: predicts header bytes and compares them.
`timescale 1ns / 100ps
module shp_byte_checker (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire               in_stall,
  input  shp_pkg::shp_in_t  in_data,
  input  wire               out_valid,
  input  wire               out_stall,
  input  shp_pkg::shp_out_t out_data,
  output int                fail_count,
  output int                bytes_outstanding,
  output int                headers_taken,
  output int                refs_taken,
  output int                headers_closed,
  output int                bytes_checked
);
  import shp_pkg::*;

  shp_out_t    header_bytes_due[$];
  logic [7:0]  item_bytes[$];
  int          tail_end;
  int          mismatches;

  logic [4:0]  refs_left;
  logic [31:0] hdr_number;
  logic        hdr_wide;
  logic [31:0] hdr_page;
  logic [31:0] hdr_length;

  task automatic add_byte(input logic [7:0] b);
    item_bytes = {item_bytes, b};
  endtask

  task automatic add_be(input logic [31:0] v, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) begin
      add_byte(8'(v >> (8 * i)));
    end
  endtask

  task automatic add_tail();
    if (hdr_wide) begin
      add_be(hdr_page, 4);
    end else begin
      add_byte(hdr_page[7:0]);
    end
    add_be(hdr_length, 4);
    tail_end = item_bytes.size() - 1;
  endtask

  // Work out the bytes one accepted item causes and queue them.
  task automatic pack_item(input shp_in_t it);
    logic [4:0]  cnt;
    logic [63:0] mask;
    logic [31:0] kept;
    int          nret;
    shp_out_t    b;
    item_bytes.delete();
    tail_end = -1;
    if (it.operation == OP_HEADER) begin
      cnt = it.ref_count;
      if (cnt > MAX_REFS) cnt = MAX_REFS;
      mask = (64'd1 << (int'(cnt) + 1)) - 64'd1;
      kept = it.retain_bits & mask[31:0];
      hdr_number = it.seg_number;
      hdr_wide   = it.wide_page_field;
      hdr_page   = it.page_assoc;
      hdr_length = (it.seg_type == SEG_TYPE_IMM_LOSSLESS) ? 32'hFFFF_FFFF : it.data_length;
      refs_left  = cnt;
      headers_taken++;
      add_be(it.seg_number, 4);
      add_byte({it.deferred_non_retain, it.wide_page_field, it.seg_type});
      if (cnt <= SHORT_FORM_MAX) begin
        add_byte({cnt[2:0], kept[4:0]});
      end else begin
        add_be({LONG_FORM_MARK, 19'd0, cnt}, 4);
        nret = (int'(cnt) + 8) / 8;
        for (int k = 0; k < nret; k++) begin
          add_byte(8'(kept >> (8 * k)));
        end
      end
      if (refs_left == 0) add_tail();
    end else if (refs_left != 0) begin
      refs_taken++;
      if (hdr_number <= REF_ONE_BYTE_MAX) begin
        add_byte(it.referred_number[7:0]);
      end else if (hdr_number <= REF_TWO_BYTE_MAX) begin
        add_be({16'd0, it.referred_number[15:0]}, 2);
      end else begin
        add_be(it.referred_number, 4);
      end
      refs_left = refs_left - 5'd1;
      if (refs_left == 0) add_tail();
    end
    for (int i = 0; i < item_bytes.size(); i++) begin
      b.out_byte        = item_bytes[i];
      b.last_of_run     = (i == item_bytes.size() - 1);
      b.header_complete = (i == tail_end);
      header_bytes_due = {header_bytes_due, b};
    end
  endtask

  always @(posedge clk) begin
    shp_out_t want;
    if (!rst_n) begin
      header_bytes_due.delete();
      refs_left      = '0;
      hdr_number     = '0;
      hdr_wide       = 1'b0;
      hdr_page       = '0;
      hdr_length     = '0;
      mismatches     = 0;
      headers_taken  = 0;
      refs_taken     = 0;
      headers_closed = 0;
      bytes_checked  = 0;
    end else begin
      // compare before predicting: a byte never comes from the item taken this edge
      if (out_valid && !out_stall) begin
        if (header_bytes_due.size() == 0) begin
          $error("unexpected byte %02h with nothing expected", out_data.out_byte);
          mismatches++;
        end else begin
          want = header_bytes_due.pop_front();
          bytes_checked++;
          if (out_data.header_complete === 1'b1) headers_closed++;
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, out_data.out_byte);
            mismatches++;
          end
          if (out_data.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                   out_data.last_of_run);
            mismatches++;
          end
          if (out_data.header_complete !== want.header_complete) begin
            $error("header_complete: expected %0b, got %0b", want.header_complete,
                   out_data.header_complete);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) pack_item(in_data);
    end
    fail_count        <= mismatches;
    bytes_outstanding <= header_bytes_due.size();
  end

endmodule

[test/tb_top.sv]
// Top of the segment header packer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
  import shp_pkg::*;

  localparam int RANDOM_ITEMS   = 120;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  shp_in_t  in_data   = '0;
  logic     out_stall = 1'b0;
  logic     in_stall;
  logic     out_valid;
  shp_out_t out_data;

  int fail_count;
  int bytes_outstanding;
  int headers_taken;
  int refs_taken;
  int headers_closed;
  int bytes_checked;

  int   idle_cycles = 0;
  int   items_sent  = 0;
  int   refs_open   = 0;
  logic sender_burst   = 1'b0;
  logic receiver_burst = 1'b0;

  segment_header_packer_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  shp_byte_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .fail_count       (fail_count),
    .bytes_outstanding(bytes_outstanding),
    .headers_taken    (headers_taken),
    .refs_taken       (refs_taken),
    .headers_closed   (headers_closed),
    .bytes_checked    (bytes_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: hold off a random number of cycles before each byte.
  initial begin
    int hold;
    forever begin
      if ($urandom_range(0, 29) == 0) receiver_burst = !receiver_burst;
      hold = receiver_burst ? 0 : $urandom_range(0, 19);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic logic [31:0] pick_number();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 256);
      1: return $urandom_range(257, 65536);
      2: begin
        case ($urandom_range(0, 5))
          0: return 32'd0;
          1: return REF_ONE_BYTE_MAX;
          2: return REF_ONE_BYTE_MAX + 32'd1;
          3: return REF_TWO_BYTE_MAX;
          4: return REF_TWO_BYTE_MAX + 32'd1;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Mostly short forms; now and then long forms up to the full count.
  function automatic logic [4:0] pick_count();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 5'($urandom_range(0, 4));
      6, 7:             return 5'($urandom_range(5, 8));
      8:                return 5'($urandom_range(9, 31));
      default:          return MAX_REFS;
    endcase
  endfunction

  function automatic shp_in_t make_header(input logic [31:0] num, input logic [4:0] cnt);
    shp_in_t it;
    it.operation           = OP_HEADER;
    it.seg_number          = num;
    it.seg_type            = ($urandom_range(0, 7) == 0) ? SEG_TYPE_IMM_LOSSLESS
                                                         : 6'($urandom_range(0, 63));
    it.wide_page_field     = 1'($urandom);
    it.deferred_non_retain = 1'($urandom);
    it.ref_count           = cnt;
    it.retain_bits         = $urandom;
    it.page_assoc          = $urandom;
    it.data_length         = $urandom;
    it.referred_number     = $urandom;
    return it;
  endfunction

  // Reference item; the header fields carry junk that must be ignored.
  function automatic shp_in_t make_ref(input logic [31:0] num);
    shp_in_t it;
    it                 = make_header($urandom, 5'($urandom));
    it.operation       = OP_REFERENCE;
    it.referred_number = num;
    return it;
  endfunction

  task automatic send_item(input shp_in_t item);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (item.operation == OP_HEADER) begin
      refs_open = int'(item.ref_count);
      items_sent++;
    end else if (refs_open != 0) begin
      refs_open--;
      items_sent++;
    end
  endtask

  // Hold the sender until every predicted byte has left the block.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (bytes_outstanding != 0);
  endtask

  initial begin
    shp_in_t    it;
    logic [4:0] cnt;
    int         stop_at;
    int         random_start;
    int         next_drain;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // all-zero header, no references: tail follows at once
    it = make_header(32'd0, 5'd0);
    it.seg_type = 6'd0;
    it.wide_page_field = 1'b0;
    it.deferred_non_retain = 1'b0;
    it.retain_bits = '0;
    it.page_assoc = '0;
    it.data_length = '0;
    send_item(it);
    // all-ones header: retain bits above the count masked
    it = make_header(32'hFFFF_FFFF, 5'd0);
    it.seg_type = 6'h3F;
    it.wide_page_field = 1'b1;
    it.deferred_non_retain = 1'b1;
    it.retain_bits = '1;
    it.page_assoc = '1;
    it.data_length = '1;
    send_item(it);
    // reference with none pending: dropped
    send_item(make_ref(32'hFFFF_FFFF));
    // immediate lossless type: length forced to all ones
    it = make_header(32'd1000, 5'd0);
    it.seg_type = SEG_TYPE_IMM_LOSSLESS;
    it.wide_page_field = 1'b0;
    it.data_length = 32'h1234_5678;
    send_item(it);
    // largest short form, one-byte references, wide numbers truncated
    it = make_header(REF_ONE_BYTE_MAX, SHORT_FORM_MAX);
    it.retain_bits = '1;
    send_item(it);
    send_item(make_ref(32'hFFFF_FFFF));
    send_item(make_ref(32'd0));
    send_item(make_ref($urandom));
    send_item(make_ref(32'h0000_00AB));
    // smallest long form, two-byte references
    it = make_header(REF_TWO_BYTE_MAX, SHORT_FORM_MAX + 5'd1);
    it.retain_bits = '1;
    it.wide_page_field = 1'b1;
    send_item(it);
    send_item(make_ref(32'hFFFF_FFFF));
    send_item(make_ref(32'd0));
    repeat (3) send_item(make_ref($urandom));
    // four-byte references
    send_item(make_header(REF_TWO_BYTE_MAX + 32'd1, 5'd2));
    send_item(make_ref(32'hFFFF_FFFF));
    send_item(make_ref(32'd0));
    // new header while references pending: drop the rest
    send_item(make_header(REF_ONE_BYTE_MAX + 32'd1, 5'd3));
    send_item(make_ref($urandom));
    it = make_header(32'd5, MAX_REFS);
    it.retain_bits = '1;
    send_item(it);
    send_item(make_header(32'd7, 5'd0));

    wait_for_drain();

    random_start = items_sent;
    next_drain = items_sent + 50;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      sender_burst = ($urandom_range(0, 3) == 0);
      if (items_sent >= next_drain) begin
        wait_for_drain();
        next_drain = items_sent + 50;
      end
      if ($urandom_range(0, 4) != 0) begin
        cnt = pick_count();
        send_item(make_header(pick_number(), cnt));
        stop_at = int'(cnt);
        // now and then break the sequence off early
        if (cnt != 0 && $urandom_range(0, 9) == 0) stop_at = $urandom_range(0, cnt - 1);
        for (int k = 0; k < stop_at; k++) begin
          send_item(make_ref(($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 300))
                                                          : $urandom));
        end
      end else if ($urandom_range(0, 1) == 0) begin
        send_item(make_ref($urandom));
      end else begin
        send_item(make_header($urandom, 5'($urandom)));
      end
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d header items and %0d reference items, short and long forms,",
             headers_taken, refs_taken);
    $display("  one-, two- and four-byte references; %0d bytes checked, %0d headers closed.",
             bytes_checked, headers_closed);
    if (fail_count == 0 && bytes_outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/shp_pkg.sv
rtl/core/segment_header_packer_unit.sv
test/shp_byte_checker.sv
test/tb_top.sv
